// ===== rtl/core/i2a_pkg.sv =====
`default_nettype none

package i2a_pkg;

   localparam int unsigned VALUE_BITS_DEFAULT = 32;

   // format selector codes (bit 1 set means hexadecimal)
   localparam logic [1:0] FUNC_UDEC = 2'd0;
   localparam logic [1:0] FUNC_SDEC = 2'd1;
   localparam logic [1:0] FUNC_HEX  = 2'd2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_HEX_A = 8'h41;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;

   localparam logic [3:0] DEC_BASE = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

   // one digit (0..15) to its ascii code
   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [3:0] off;
      off = d - DEC_BASE;
      if (d >= DEC_BASE) begin
         return CHAR_HEX_A + {4'd0, off};
      end else begin
         return CHAR_ZERO + {4'd0, d};
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter_core.sv =====
`default_nettype none

// Integer to ASCII formatter. Each input transfer carries a value and a
// format code (0 unsigned decimal, 1 signed decimal, 2 or 3 uppercase hex);
// the block answers with one output transfer per character, most
// significant first, no leading zeros, a lone '0' for zero, and a leading
// '-' for a negative signed value (the most negative value prints its full
// magnitude). rsp_last marks the final character of each value. The block
// takes one value at a time: req_ready is high only while it is idle. A
// decimal value runs through a bit-serial shift-and-add-3 (double dabble)
// converter, then leading zero digits are dropped and digits are sent, one
// digit slot per cycle while the output is not stalled. A hex value skips
// the converter. The output register lets a new value be accepted while
// the final character still waits to be taken.
module integer_to_ascii_formatter_core #(
   parameter int unsigned VALUE_BITS = i2a_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_func,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_char_code,
   output logic                       rsp_last
);
   import i2a_pkg::*;

   // decimal digits of 2^VALUE_BITS - 1, using log10(2) ~ 0.30103
   localparam int unsigned DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int unsigned HEX_DIGITS = (VALUE_BITS + 3) / 4;
   localparam int unsigned NUM_DIGITS = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
   localparam int unsigned DIG_W      = NUM_DIGITS * 4;
   localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
   localparam int unsigned BIT_W      = $clog2(VALUE_BITS + 1);

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;        // magnitude shifting into the converter
   logic [DIG_W-1:0]      digits_ff, digits_in;  // bcd or hex digits, right aligned
   logic [CNT_W-1:0]      cnt_ff, cnt_in;        // digit slots still to look at
   logic [BIT_W-1:0]      bits_ff, bits_in;      // converter bits remaining
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic                  out_free;
   logic                  is_hex;
   logic                  is_neg;
   logic [VALUE_BITS-1:0] mag_load;
   logic [DIG_W-1:0]      adjusted;
   logic [3:0]            top_digit;
   logic [DIG_W-1:0]      digits_shl;

   assign accept   = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // input decode: two's complement magnitude fits in VALUE_BITS unsigned bits
   assign is_hex   = req_func[1];
   assign is_neg   = (req_func == FUNC_SDEC) & req_value[VALUE_BITS-1];
   assign mag_load = is_neg ? (~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;

   // double dabble: add 3 to every bcd digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adjusted[4*i +: 4] = (digits_ff[4*i +: 4] >= 4'd5) ?
                              (digits_ff[4*i +: 4] + 4'd3) : digits_ff[4*i +: 4];
      end
   end

   assign top_digit  = digits_ff[DIG_W-1 -: 4];
   assign digits_shl = {digits_ff[DIG_W-5:0], 4'd0};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = is_hex ? ST_SKIP : ST_CONV;
            end
         end
         ST_CONV: begin
            if (bits_ff == BIT_W'(1)) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit != 4'd0 || cnt_ff == CNT_W'(1)) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && cnt_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      mag_in       = mag_ff;
      digits_in    = digits_ff;
      cnt_in       = cnt_ff;
      bits_in      = bits_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      char_in      = char_ff;
      last_in      = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in    = mag_load;
               neg_in    = is_neg;
               cnt_in    = CNT_W'(NUM_DIGITS);
               bits_in   = BIT_W'(VALUE_BITS);
               digits_in = is_hex ? DIG_W'(mag_load) : '0;
            end
         end
         ST_CONV: begin
            digits_in = {adjusted[DIG_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in    = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bits_in   = bits_ff - BIT_W'(1);
         end
         ST_SKIP: begin
            // drop a leading zero, but always keep the last digit
            if (top_digit == 4'd0 && cnt_ff != CNT_W'(1)) begin
               digits_in = digits_shl;
               cnt_in    = cnt_ff - CNT_W'(1);
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_MINUS;
               last_in      = 1'b0;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = digit_char(top_digit);
               last_in      = (cnt_ff == CNT_W'(1));
               digits_in    = digits_shl;
               cnt_in       = cnt_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      digits_ff <= digits_in;
      cnt_ff    <= cnt_in;
      bits_ff   <= bits_in;
      neg_ff    <= neg_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/i2a_core_checker.sv =====
`default_nettype none

module i2a_core_checker #(
   parameter int unsigned VALUE_BITS = i2a_pkg::VALUE_BITS_DEFAULT
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic [1:0]            req_func,
   input wire logic [VALUE_BITS-1:0] req_value,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [7:0]            rsp_char_code,
   input wire logic                  rsp_last
);
   import i2a_pkg::*;

   logic code_ok;

   assign code_ok = (rsp_char_code >= CHAR_ZERO && rsp_char_code <= (CHAR_ZERO + 8'd9))
                 || (rsp_char_code >= CHAR_HEX_A && rsp_char_code <= (CHAR_HEX_A + 8'd5))
                 || (rsp_char_code == CHAR_MINUS);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char_code) && $stable(rsp_last))
      else $error("stalled result changed");

   // a waiting request holds its payload
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_func) && $stable(req_value))
      else $error("waiting request changed");

   // one value at a time: busy right after a value is taken
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after input transfer");

   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> code_ok)
      else $error("illegal character code");

   // a sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_char_code == CHAR_MINUS |-> !rsp_last)
      else $error("minus sign flagged last");

endmodule

bind integer_to_ascii_formatter_core i2a_core_checker #(
   .VALUE_BITS (VALUE_BITS)
) u_i2a_core_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_func      (req_func),
   .req_value     (req_value),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_char_code (rsp_char_code),
   .rsp_last      (rsp_last)
);

`default_nettype wire

// ===== dv/tb_integer_to_ascii_formatter_core.sv =====
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter_core;
   import i2a_pkg::*;

   localparam int unsigned VALUE_BITS = 32;
   // code 3 is not named in the package; bit 1 set still selects hex
   localparam logic [1:0] FUNC_HEX_ALT = 2'd3;

   localparam int RANDOM_ITEMS = 400;
   localparam int IDLE_PCT     = 30;
   // random items in this window run with both sides never idling
   localparam int CALM_FIRST   = 150;
   localparam int CALM_LAST    = 230;
   localparam int MAX_GAP      = 20;
   localparam int DRAIN_CYCLES = 120;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } ascii_char_type;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_func  = FUNC_UDEC;
   logic [VALUE_BITS-1:0] req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [7:0]            rsp_char_code;
   logic                  rsp_last;

   // characters still owed by the block, oldest first
   ascii_char_type pending_chars[$];
   int             error_count = 0;
   int             idle_pct    = IDLE_PCT;

   // directed table: format, value, and the text where it is obvious
   logic [1:0]            dir_func[$];
   logic [VALUE_BITS-1:0] dir_value[$];
   string                 dir_text[$];

   integer_to_ascii_formatter_core #(
      .VALUE_BITS(VALUE_BITS)
   ) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("integer_to_ascii_formatter_core test failed");
      $finish;
   end

   task automatic add_row(input logic [1:0] f, input logic [VALUE_BITS-1:0] v,
                          input string t);
      dir_func.push_back(f);
      dir_value.push_back(v);
      dir_text.push_back(t);
   endtask

   // queue a typed-in text, last flag on its final character
   function automatic void queue_text(input string t);
      for (int i = 0; i < t.len(); i++) begin
         pending_chars.push_back({t[i], i == t.len() - 1});
      end
   endfunction

   // work out the printed text of one value and queue its characters
   function automatic void queue_rendering(input logic [1:0] f,
                                           input logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS:0] mag;
      logic [4:0]          radix;
      logic [3:0]          digit;
      logic [7:0]          glyphs[$];
      logic                negative;
      radix    = f[1] ? 5'd16 : 5'd10;
      negative = (f == FUNC_SDEC) && v[VALUE_BITS-1];
      // one extra bit so the most negative value keeps its magnitude
      mag      = negative ? '0 - {1'b1, v} : {1'b0, v};
      do begin
         digit = 4'(mag % radix);
         mag   = mag / radix;
         if (digit >= 4'd10) begin
            glyphs.push_front(CHAR_HEX_A + 8'(digit) - 8'd10);
         end else begin
            glyphs.push_front(CHAR_ZERO + 8'(digit));
         end
      end while (mag != 0);
      if (negative) begin
         glyphs.push_front(CHAR_MINUS);
      end
      for (int i = 0; i < glyphs.size(); i++) begin
         pending_chars.push_back({glyphs[i], i == glyphs.size() - 1});
      end
   endfunction

   // random operand biased toward digit-count and sign boundaries
   function automatic logic [VALUE_BITS-1:0] pick_operand();
      logic [VALUE_BITS-1:0] tens;
      int unsigned           k;
      k    = $urandom_range(VALUE_BITS - 1);
      tens = 32'd1;
      case ($urandom_range(5))
         0: return $urandom_range(1000);
         1: return 32'd1 << k;
         2: return (32'd1 << k) - 32'd1;
         3: return 32'd0 - $urandom_range(1000);
         4: begin
            // around a power of ten, where the digit count changes
            repeat ($urandom_range(9)) tens = tens * 32'd10;
            return tens + $urandom_range(2) - 32'd1;
         end
         default: return $urandom();
      endcase
   endfunction

   // one request transfer; the expected text is queued once it is taken
   task automatic transfer_value(input logic [1:0] f, input logic [VALUE_BITS-1:0] v,
                                 input string t);
      int gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         // idle cycles; payload is junk while valid is low
         req_valid <= 1'b0;
         req_func  <= 2'($urandom_range(3));
         req_value <= $urandom();
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func  <= f;
      req_value <= v;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (t.len() > 0) begin
         queue_text(t);
      end else begin
         queue_rendering(f, v);
      end
   endtask

   // response side back-pressure
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // compare each character transfer with the oldest one owed
   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_chars.size() == 0) begin
            $error("rsp_char_code: expected none, actual %h", rsp_char_code);
            error_count++;
         end else begin
            want = pending_chars.pop_front();
            if (rsp_char_code !== want.code) begin
               $error("rsp_char_code: expected %h, actual %h", want.code, rsp_char_code);
               error_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %b, actual %b", want.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin
      // zero in every format
      add_row(FUNC_UDEC,    32'h0000_0000, "0");
      add_row(FUNC_SDEC,    32'h0000_0000, "0");
      add_row(FUNC_HEX,     32'h0000_0000, "0");
      add_row(FUNC_HEX_ALT, 32'h0000_0000, "0");
      // all ones
      add_row(FUNC_UDEC,    32'hFFFF_FFFF, "4294967295");
      add_row(FUNC_SDEC,    32'hFFFF_FFFF, "-1");
      add_row(FUNC_HEX,     32'hFFFF_FFFF, "FFFFFFFF");
      add_row(FUNC_HEX_ALT, 32'hFFFF_FFFF, "FFFFFFFF");
      // sign boundary, most negative value included
      add_row(FUNC_SDEC,    32'h8000_0000, "-2147483648");
      add_row(FUNC_UDEC,    32'h8000_0000, "2147483648");
      add_row(FUNC_SDEC,    32'h7FFF_FFFF, "2147483647");
      add_row(FUNC_HEX,     32'h8000_0000, "80000000");
      // digit roll-overs and letter digits
      add_row(FUNC_UDEC,    32'd9,         "9");
      add_row(FUNC_UDEC,    32'd10,        "10");
      add_row(FUNC_HEX,     32'h0000_000A, "A");
      add_row(FUNC_HEX,     32'h0000_000F, "F");
      add_row(FUNC_HEX,     32'h0000_0010, "10");
      add_row(FUNC_HEX_ALT, 32'hABCD_EF01, "ABCDEF01");
      add_row(FUNC_SDEC,    32'hFFFF_FFF6, "-10");
      add_row(FUNC_UDEC,    32'd1000000000, "1000000000");
      add_row(FUNC_UDEC,    32'd999999999,  "999999999");
      // mixed digits, left to the predictor
      add_row(FUNC_UDEC,    32'h1234_5678, "");
      add_row(FUNC_SDEC,    32'hDEAD_BEEF, "");
      add_row(FUNC_HEX,     32'h00C0_FFEE, "");
      add_row(FUNC_HEX_ALT, 32'h55AA_55AA, "");

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_func[i]) begin
         transfer_value(dir_func[i], dir_value[i], dir_text[i]);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         idle_pct = (n >= CALM_FIRST && n < CALM_LAST) ? 0 : IDLE_PCT;
         transfer_value(2'($urandom_range(3)), pick_operand(), "");
      end
      idle_pct  = IDLE_PCT;
      req_valid <= 1'b0;

      // drain, then give stray characters a chance to show up
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("integer_to_ascii_formatter_core test passed");
      end else begin
         $display("integer_to_ascii_formatter_core test failed");
      end
      $finish;
   end

endmodule
